### hdl/i2crts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crts_pkg
// types, codes and status checks shared by the i2c register sequencer
// ----------------------------------------------------------------------------
package i2crts_pkg;

    localparam int REQ_W = 48;
    localparam int RES_W = 16;

    typedef enum logic [2:0] {
        OP_BEGIN_WRITE = 3'd0,
        OP_BEGIN_READ  = 3'd1,
        OP_BEGIN_PROBE = 3'd2,
        OP_WRITE_DATA  = 3'd3,
        OP_COMPLETION  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START      = 4'd1,
        PH_ADDR       = 4'd2,
        PH_REG        = 4'd3,
        PH_WAIT_DATA  = 4'd4,
        PH_RESTART    = 4'd5,
        PH_DATA       = 4'd6,
        PH_PROBE_READ = 4'd7,
        PH_READ_ADDR  = 4'd8,
        PH_READING    = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_PROBE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_ADDRESS = 3'd1,
        ACT_DATA    = 3'd2,
        ACT_READ    = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_DONE    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        OUT_OK      = 2'd0,
        OUT_NOACK   = 2'd1,
        OUT_NODEV   = 2'd2,
        OUT_STARTER = 2'd3
    } t_outcome;

    localparam logic [7:0] STATUS_MASK    = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_DATA_ACK    = 8'h28;
    localparam logic [7:0] RW_CLEAR       = 8'hFE;
    localparam logic [7:0] RW_SET         = 8'h01;

    typedef struct packed {
        t_phase     phase;
        t_kind      kind;
        logic [7:0] address;
        logic [7:0] reg_index;
        logic [7:0] remaining;
    } t_ctx;

    typedef struct packed {
        t_outcome   outcome;
        logic       is_done;
        logic       ack_after_read;
        logic [7:0] action_byte;
        t_action    action;
    } t_result;

    typedef struct packed {
        t_op        operation;
        logic [7:0] device_address;
        logic [7:0] register_start;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic [7:0] bus_status;
    } t_request;

    function automatic logic start_ok(input logic [7:0] st);
        logic [7:0] m;
        m = st & STATUS_MASK;
        return (m == ST_START) || (m == ST_RESTART);
    endfunction

    function automatic logic addr_ok(input logic [7:0] st);
        logic [7:0] m;
        m = st & STATUS_MASK;
        return (m == ST_ADDR_W_ACK) || (m == ST_ADDR_R_ACK);
    endfunction

    function automatic logic data_ok(input logic [7:0] st);
        return (st & STATUS_MASK) == ST_DATA_ACK;
    endfunction

    function automatic t_result mk_result(input t_action act, input logic [7:0] byte_val,
                                          input logic ack, input logic done,
                                          input t_outcome outc);
        t_result r;
        r.action         = act;
        r.action_byte    = byte_val;
        r.ack_after_read = ack;
        r.is_done        = done;
        r.outcome        = outc;
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/i2c_register_transaction_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer_top
// i2c master register write, read and probe sequencing above a byte engine
// ----------------------------------------------------------------------------
// Each accepted request is decided in the cycle it is accepted and its up to
// three results are loaded into a result bank, then handed out one per cycle
// on the master side while i_m_tready is high. A one-result request sustains
// one request per clock while the master does not stall; a request yielding
// more holds the output until all have left, and the next request is taken in
// the cycle the last of them leaves. A request with no result takes no output
// cycle but, like any other, is only taken while the result bank is empty or
// draining its last result. It has no config registers or reset clearing pass.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // operation[2:0], device_address[10:3], register_start[18:11],
    // byte_count[26:19], data_byte[34:27], bus_status[42:35], zero[47:43]
    input  wire  [i2crts_pkg::REQ_W-1:0]     i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // action[2:0], action_byte[10:3], ack_after_read[11], is_done[12],
    // outcome[14:13], zero[15]
    output logic [i2crts_pkg::RES_W-1:0]     o_m_tdata,
    output logic                             o_m_tlast
);
    import i2crts_pkg::*;

    t_ctx       r_ctx;
    t_ctx       n_ctx;
    t_request   s_req;
    t_result    s_res [3];
    logic [1:0] s_count;
    t_result    r_res [3];
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       s_take;
    logic       s_drain;
    logic       s_accept;

    assign s_req = t_request'({i_s_tdata[2:0], i_s_tdata[10:3], i_s_tdata[18:11],
                               i_s_tdata[26:19], i_s_tdata[34:27], i_s_tdata[42:35]});

    i2crts_step u_step (
        .i_ctx   (r_ctx),
        .i_req   (s_req),
        .o_ctx   (n_ctx),
        .o_res   (s_res),
        .o_count (s_count)
    );

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign s_take     = o_m_tvalid && i_m_tready;
    assign s_drain    = s_take && (r_idx == r_cnt - 2'd1);
    assign o_s_tready = (r_cnt == 2'd0) || s_drain;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tdata  = {1'b0, r_res[r_idx]};
    assign o_m_tlast  = (r_idx == r_cnt - 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '{phase: PH_IDLE, kind: KIND_WRITE, default: '0};
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            if (s_accept) begin
                r_ctx <= n_ctx;
            end
            if (s_accept && s_count != 2'd0) begin
                r_cnt <= s_count;
                r_idx <= 2'd0;
            end else if (s_drain) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else if (s_take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && s_count != 2'd0) begin
            r_res <= s_res;
        end
    end

endmodule
`default_nettype wire

### hdl/i2crts_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crts_step
// decides one request: next transaction context and up to three results
// ----------------------------------------------------------------------------
module i2crts_step (
    input  wire  i2crts_pkg::t_ctx     i_ctx,
    input  wire  i2crts_pkg::t_request i_req,
    output i2crts_pkg::t_ctx           o_ctx,
    output i2crts_pkg::t_result        o_res [3],
    output logic [1:0]                 o_count
);
    import i2crts_pkg::*;

    always_comb begin
        t_ctx       c;
        t_result    r [3];
        logic [1:0] n;
        logic [7:0] st;
        logic [7:0] dec;

        c   = i_ctx;
        n   = 2'd0;
        st  = i_req.bus_status;
        dec = i_ctx.remaining - 8'd1;
        for (int k = 0; k < 3; k++) begin
            r[k] = mk_result(ACT_START, 8'd0, 1'b0, 1'b0, OUT_OK);
        end

        case (i_req.operation)
            OP_BEGIN_WRITE, OP_BEGIN_READ, OP_BEGIN_PROBE: begin
                c.kind      = t_kind'(i_req.operation[1:0]);
                c.address   = i_req.device_address;
                c.reg_index = i_req.register_start;
                c.remaining = i_req.byte_count;
                c.phase     = PH_START;
                r[0] = mk_result(ACT_START, 8'd0, 1'b0, 1'b0, OUT_OK);
                n    = 2'd1;
            end
            OP_WRITE_DATA: begin
                if (i_ctx.phase == PH_WAIT_DATA && i_ctx.remaining != 8'd0) begin
                    c.remaining = dec;
                    c.phase     = PH_DATA;
                    r[0] = mk_result(ACT_DATA, i_req.data_byte, 1'b0, 1'b0, OUT_OK);
                    n    = 2'd1;
                end
            end
            OP_COMPLETION: begin
                case (i_ctx.phase)
                    PH_START, PH_RESTART: begin
                        if (!start_ok(st)) begin
                            r[0] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                            r[1] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_STARTER);
                            n    = 2'd2;
                            c.phase = PH_IDLE;
                        end else if (i_ctx.phase == PH_RESTART) begin
                            c.phase = PH_READ_ADDR;
                            r[0] = mk_result(ACT_ADDRESS, i_ctx.address | RW_SET,
                                             1'b0, 1'b0, OUT_OK);
                            n    = 2'd1;
                        end else begin
                            c.phase = PH_ADDR;
                            r[0] = mk_result(ACT_ADDRESS,
                                             (i_ctx.kind == KIND_PROBE) ? i_ctx.address
                                                 : (i_ctx.address & RW_CLEAR),
                                             1'b0, 1'b0, OUT_OK);
                            n    = 2'd1;
                        end
                    end
                    PH_ADDR, PH_READ_ADDR: begin
                        if (!addr_ok(st)) begin
                            r[0] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                            r[1] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_NODEV);
                            n    = 2'd2;
                            c.phase = PH_IDLE;
                        end else if (i_ctx.phase == PH_READ_ADDR) begin
                            if (i_ctx.remaining == 8'd0) begin
                                r[0] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                                r[1] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_OK);
                                n    = 2'd2;
                                c.phase = PH_IDLE;
                            end else begin
                                c.phase = PH_READING;
                                r[0] = mk_result(ACT_READ, 8'd0, i_ctx.remaining > 8'd1,
                                                 1'b0, OUT_OK);
                                n    = 2'd1;
                            end
                        end else if (i_ctx.kind == KIND_PROBE) begin
                            if (i_ctx.address[0]) begin
                                c.phase = PH_PROBE_READ;
                                r[0] = mk_result(ACT_READ, 8'd0, 1'b0, 1'b0, OUT_OK);
                                n    = 2'd1;
                            end else begin
                                r[0] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                                r[1] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_OK);
                                n    = 2'd2;
                                c.phase = PH_IDLE;
                            end
                        end else begin
                            c.phase = PH_REG;
                            r[0] = mk_result(ACT_DATA, i_ctx.reg_index, 1'b0, 1'b0, OUT_OK);
                            n    = 2'd1;
                        end
                    end
                    PH_REG, PH_DATA: begin
                        if (!data_ok(st)) begin
                            r[0] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                            r[1] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_NOACK);
                            n    = 2'd2;
                            c.phase = PH_IDLE;
                        end else if (i_ctx.phase == PH_REG && i_ctx.kind == KIND_READ) begin
                            c.phase = PH_RESTART;
                            r[0] = mk_result(ACT_START, 8'd0, 1'b0, 1'b0, OUT_OK);
                            n    = 2'd1;
                        end else if (i_ctx.remaining == 8'd0) begin
                            r[0] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                            r[1] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_OK);
                            n    = 2'd2;
                            c.phase = PH_IDLE;
                        end else begin
                            c.phase = PH_WAIT_DATA;
                        end
                    end
                    PH_READING: begin
                        r[0] = mk_result(ACT_DONE, i_req.data_byte, 1'b0, 1'b0, OUT_OK);
                        c.remaining = dec;
                        if (dec == 8'd0) begin
                            r[1] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                            r[2] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_OK);
                            n    = 2'd3;
                            c.phase = PH_IDLE;
                        end else begin
                            r[1] = mk_result(ACT_READ, 8'd0, dec > 8'd1, 1'b0, OUT_OK);
                            n    = 2'd2;
                        end
                    end
                    PH_PROBE_READ: begin
                        r[0] = mk_result(ACT_STOP, 8'd0, 1'b0, 1'b0, OUT_OK);
                        r[1] = mk_result(ACT_DONE, 8'd0, 1'b0, 1'b1, OUT_OK);
                        n    = 2'd2;
                        c.phase = PH_IDLE;
                    end
                    default: begin
                        n = 2'd0;
                    end
                endcase
            end
            default: begin
                n = 2'd0;
            end
        endcase

        o_ctx   = c;
        o_res   = r;
        o_count = n;
    end

endmodule
`default_nettype wire

### hdl/i2crts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crts_checker
// port-level checks on the result stream of the i2c register sequencer
// ----------------------------------------------------------------------------
module i2crts_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_s_tready,
    input wire                          o_m_tvalid,
    input wire                          i_m_tready,
    input wire [i2crts_pkg::RES_W-1:0]  o_m_tdata,
    input wire                          o_m_tlast
);
    import i2crts_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // closing result is last of its request
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[12] |-> o_m_tlast)
        else $error("done result not last");

    // stop is always followed by done
    a_stop_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] == ACT_STOP |-> !o_m_tlast)
        else $error("stop marked last");

    // error outcome only on a done result
    a_outcome_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[14:13] != OUT_OK |-> o_m_tdata[12])
        else $error("outcome on non-done result");

    // no new request taken while results remain after this cycle
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request taken mid-burst");

endmodule

bind i2c_register_transaction_sequencer_top i2crts_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire
